>>> sv/hud_text_bar_overlay_unit_assert.svh
// Assertion macros used by the overlay top level, hud_text_bar_overlay_unit.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef HUD_TEXT_BAR_OVERLAY_UNIT_ASSERT_SVH
`define HUD_TEXT_BAR_OVERLAY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HUD_OSD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("overlay check failed");

// The consequent must hold in the cycle after the antecedent.
`define HUD_OSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("overlay check failed");

`endif

>>> sv/hud_osd_pkg.sv
// Package for the text bar overlay: geometry constants, word types, register
// indexes and the 5x7 font lookup. No dependencies.
package hud_osd_pkg;

	localparam int DEF_FRAME_WIDTH  = 640;
	localparam int DEF_FRAME_HEIGHT = 640;
	localparam int DEF_MAX_CHARS    = 32;

	localparam int BAR_W      = 244;
	localparam int BAR_H      = 28;
	localparam int BAR_TOP    = 6;
	localparam int TEXT_DX    = 4;
	localparam int TEXT_DY    = 4;
	localparam int CELL_PITCH = 6;
	localparam int GLYPH_W    = 5;
	localparam int GLYPH_H    = 7;
	localparam int NUM_GLYPHS = 25;

	localparam int TEXT_SLOTS = 32;
	localparam int TEXT_BITS  = TEXT_SLOTS * 8;
	localparam int SLOT_W     = 5;
	localparam int COORD_W    = 13;
	localparam int OFFS_W     = 8;
	localparam int DIV6_MUL   = 171;
	localparam int DIV6_SHIFT = 10;

	localparam logic [23:0] COLOR_RESET = 24'h00FF00;

	typedef enum logic [2:0] {
		REG_CHARS_A = 3'd0,
		REG_CHARS_B = 3'd1,
		REG_CHARS_C = 3'd2,
		REG_CHARS_D = 3'd3,
		REG_COLOR   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [9:0] x;
		logic [9:0] y;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} pix_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} rgba_t;

	typedef logic [4:0] font_row_t;

	localparam font_row_t FONT [0:NUM_GLYPHS-1][0:GLYPH_H-1] = '{
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
		'{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F},
		'{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
		'{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
		'{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
		'{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		'{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
		'{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00},
		'{5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00},
		'{5'h04, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h04},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11},
		'{5'h06, 5'h09, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h08},
		'{5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E},
		'{5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10},
		'{5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E},
		'{5'h00, 5'h00, 5'h1B, 5'h15, 5'h15, 5'h15, 5'h15},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
	};

	// Font row for a character code; codes outside the font give the blank glyph.
	function automatic font_row_t glyph_row(input logic [7:0] code, input logic [2:0] row);
		logic [4:0] idx;
		font_row_t bits;
		unique case (code)
			8'h30: idx = 5'd0;
			8'h31: idx = 5'd1;
			8'h32: idx = 5'd2;
			8'h33: idx = 5'd3;
			8'h34: idx = 5'd4;
			8'h35: idx = 5'd5;
			8'h36: idx = 5'd6;
			8'h37: idx = 5'd7;
			8'h38: idx = 5'd8;
			8'h39: idx = 5'd9;
			8'h2E: idx = 5'd10;
			8'h3A: idx = 5'd11;
			8'h7C: idx = 5'd12;
			8'h20: idx = 5'd13;
			8'h49: idx = 5'd14;
			8'h6E: idx = 5'd15;
			8'h66: idx = 5'd16;
			8'h65: idx = 5'd17;
			8'h72: idx = 5'd18;
			8'h73: idx = 5'd19;
			8'h6D: idx = 5'd20;
			8'h46: idx = 5'd21;
			8'h50: idx = 5'd22;
			8'h53: idx = 5'd23;
			default: idx = 5'd24;
		endcase
		if (row < 3'(GLYPH_H)) begin
			bits = FONT[idx][row];
		end else begin
			bits = '0;
		end
		return bits;
	endfunction

endpackage

>>> sv/hud_osd_shade.sv
// Per-pixel overlay datapath: bar darkening, text cell decode and font lookup.
// Purely combinational; depends on hud_osd_pkg.
module hud_osd_shade import hud_osd_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
	parameter int MAX_CHARS    = DEF_MAX_CHARS
) (
	input  pix_t                   pix,
	input  logic [TEXT_BITS-1:0]   text,
	input  logic [23:0]            color,
	output rgba_t                  result
);

	localparam int BAR_LEFT  = (FRAME_WIDTH > BAR_W) ? FRAME_WIDTH - BAR_W : 0;
	localparam int TEXT_X    = BAR_LEFT + TEXT_DX;
	localparam int TEXT_Y    = BAR_TOP + TEXT_DY;
	localparam int FIT_CELLS = (FRAME_WIDTH >= TEXT_X + GLYPH_W &&
		FRAME_HEIGHT >= TEXT_Y + GLYPH_H) ?
		(FRAME_WIDTH - TEXT_X - GLYPH_W) / CELL_PITCH + 1 : 0;
	localparam int NUM_CELLS = (MAX_CHARS < FIT_CELLS) ? MAX_CHARS : FIT_CELLS;
	localparam int TEXT_SPAN = NUM_CELLS * CELL_PITCH;

	logic [COORD_W-1:0]        x, y, dx, dy;
	logic                      in_frame, in_bar, in_text, lit;
	logic [OFFS_W-1:0]         offs, cell_base;
	logic [OFFS_W+7:0]         prod;
	logic [SLOT_W-1:0]         slot;
	logic [2:0]                col, row;
	logic [TEXT_SLOTS-1:0]     nz, live;
	logic [7:0]                code;
	font_row_t                 bits;

	always_comb begin
		x = {{(COORD_W-10){1'b0}}, pix.x};
		y = {{(COORD_W-10){1'b0}}, pix.y};
		in_frame = x < COORD_W'(FRAME_WIDTH) && y < COORD_W'(FRAME_HEIGHT);
		in_bar = in_frame && x >= COORD_W'(BAR_LEFT) && x < COORD_W'(BAR_LEFT + BAR_W) &&
			y >= COORD_W'(BAR_TOP) && y < COORD_W'(BAR_TOP + BAR_H);

		dx = x - COORD_W'(TEXT_X);
		dy = y - COORD_W'(TEXT_Y);
		in_text = in_frame && x >= COORD_W'(TEXT_X) && dx < COORD_W'(TEXT_SPAN) &&
			y >= COORD_W'(TEXT_Y) && y < COORD_W'(TEXT_Y + GLYPH_H);

		// Cell index is offs / 6 by reciprocal multiply, exact for offs below 192.
		offs = dx[OFFS_W-1:0];
		prod = {8'b0, offs} * (OFFS_W+8)'(DIV6_MUL);
		slot = prod[DIV6_SHIFT +: SLOT_W];
		cell_base = {{(OFFS_W-SLOT_W){1'b0}}, slot} * OFFS_W'(CELL_PITCH);
		col = 3'(offs - cell_base);
		row = dy[2:0];

		// A cell is live when it and every character before it are nonzero.
		for (int i = 0; i < TEXT_SLOTS; i++) begin
			nz[i] = |text[i*8 +: 8];
		end
		for (int i = 0; i < TEXT_SLOTS; i++) begin
			live[i] = &(nz | ~((32'd2 << i) - 32'd1));
		end

		code = text[{slot, 3'b000} +: 8];
		bits = glyph_row(code, row);
		lit = in_text && live[slot] && (|(bits & (5'b10000 >> col)));

		if (lit) begin
			result.blue  = color[23:16];
			result.green = color[15:8];
			result.red   = color[7:0];
			result.alpha = 8'hFF;
		end else if (in_bar) begin
			result.blue  = {1'b0, pix.blue[7:1]};
			result.green = {1'b0, pix.green[7:1]};
			result.red   = {1'b0, pix.red[7:1]};
			result.alpha = pix.alpha;
		end else begin
			result.blue  = pix.blue;
			result.green = pix.green;
			result.red   = pix.red;
			result.alpha = pix.alpha;
		end
	end

endmodule

>>> sv/hud_text_bar_overlay_unit.sv
// Top level of the text bar overlay: handshake, configuration registers and
// the two pipeline registers around hud_osd_shade. Depends on hud_osd_pkg.
`include "hud_text_bar_overlay_unit_assert.svh"

// Overlays a darkened 244x28 bar at the top right of the frame and a line of
// 5x7 text on one BGRA pixel word at a time. The unit takes one word per clock
// while in_stall is low and passes it through the input and result registers,
// with the cell decode and font lookup in the single stage between them. A
// finished word waiting in the result register does not block a new input
// word while the input register is empty. The user must write configuration
// via cfg_write, cfg_index, cfg_data while no word is in flight; not enforced.
module hud_text_bar_overlay_unit import hud_osd_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
	parameter int MAX_CHARS    = DEF_MAX_CHARS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic [7:0]  out_alpha
);

	logic [TEXT_BITS-1:0] text_q;
	logic [23:0]          color_q;
	logic                 valid_s1, valid_s2;
	logic                 adv_s1, adv_s2;
	pix_t                 pix_s1;
	rgba_t                shade, res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q  <= '0;
			color_q <= COLOR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CHARS_A: text_q[0*64 +: 64] <= cfg_data;
				REG_CHARS_B: text_q[1*64 +: 64] <= cfg_data;
				REG_CHARS_C: text_q[2*64 +: 64] <= cfg_data;
				REG_CHARS_D: text_q[3*64 +: 64] <= cfg_data;
				REG_COLOR:   color_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			pix_s1 <= '{x: pixel_x, y: pixel_y, blue: in_blue, green: in_green,
				red: in_red, alpha: in_alpha};
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= shade;
		end
	end

	hud_osd_shade #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT),
		.MAX_CHARS   (MAX_CHARS)
	) u_shade (
		.pix   (pix_s1),
		.text  (text_q),
		.color (color_q),
		.result(shade)
	);

	assign out_valid = valid_s2;
	assign out_blue  = res_s2.blue;
	assign out_green = res_s2.green;
	assign out_red   = res_s2.red;
	assign out_alpha = res_s2.alpha;

	`HUD_OSD_ASSERT_NEXT(a_s1_kept, valid_s1 && !adv_s2, valid_s1)
	`HUD_OSD_ASSERT_NEXT(a_s1_moves, valid_s1 && adv_s2, out_valid)
	`HUD_OSD_ASSERT_NEXT(a_no_phantom, out_valid && !out_stall && !valid_s1, !out_valid)
	`HUD_OSD_ASSERT_NOW(a_full_stalls, out_valid && out_stall && valid_s1, in_stall)

endmodule

>>> bench/tb_hud_text_bar_overlay_unit.sv
// Testbench for hud_text_bar_overlay_unit. It predicts every BGRA word from its own bar and font
// model, checks each output word in order, and sweeps text and color settings under stalls.
// Depends on hud_osd_pkg and the RTL of the overlay unit only.
module tb_hud_text_bar_overlay_unit;
	import hud_osd_pkg::cfg_reg_t;
	import hud_osd_pkg::REG_CHARS_A;
	import hud_osd_pkg::REG_CHARS_B;
	import hud_osd_pkg::REG_CHARS_C;
	import hud_osd_pkg::REG_CHARS_D;
	import hud_osd_pkg::REG_COLOR;

	localparam int FRAME_W = 640;
	localparam int FRAME_H = 640;
	localparam int TEXT_CHARS = 32;
	localparam int BAR_WIDTH = 244;
	localparam int BAR_HEIGHT = 28;
	localparam int BAR_ROW = 6;
	localparam int BAR_LEFT = (FRAME_W > BAR_WIDTH) ? FRAME_W - BAR_WIDTH : 0;
	localparam int TEXT_LEFT = BAR_LEFT + 4;
	localparam int TEXT_ROW = BAR_ROW + 4;
	localparam int PITCH = 6;
	localparam int CHAR_W = 5;
	localparam int CHAR_H = 7;
	localparam logic [23:0] GREEN = 24'h00FF00;
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [9:0] x;
		logic [9:0] y;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} pixel_word_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} shade_t;

	class pixel_overlay_tracker;
		shade_t expected_pixels[$];
		logic [TEXT_CHARS*8-1:0] text_bits;
		logic [23:0] color;
		int mismatches;

		function new();
			text_bits = '0;
			color = GREEN;
			mismatches = 0;
		endfunction

		function void set_register(logic [2:0] index, logic [63:0] data);
			case (index)
				REG_CHARS_A: text_bits[63:0] = data;
				REG_CHARS_B: text_bits[127:64] = data;
				REG_CHARS_C: text_bits[191:128] = data;
				REG_CHARS_D: text_bits[255:192] = data;
				REG_COLOR: color = data[23:0];
				default: ;
			endcase
		endfunction

		function logic [4:0] font_row(logic [7:0] code, int row);
			logic [4:0] rows [7];
			case (code)
				"0": rows = '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
				"1": rows = '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
				"2": rows = '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
				"3": rows = '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
				"4": rows = '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
				"5": rows = '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
				"6": rows = '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
				"7": rows = '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
				"8": rows = '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
				"9": rows = '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E};
				".": rows = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
				":": rows = '{5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00};
				"|": rows = '{5'h04, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h04};
				"I": rows = '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
				"n": rows = '{5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
				"f": rows = '{5'h06, 5'h09, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h08};
				"e": rows = '{5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
				"r": rows = '{5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
				"s": rows = '{5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
				"m": rows = '{5'h00, 5'h00, 5'h1B, 5'h15, 5'h15, 5'h15, 5'h15};
				"F": rows = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
				"P": rows = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
				"S": rows = '{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
				default: rows = '{default: 5'h00};
			endcase
			return rows[row];
		endfunction

		function shade_t overlay_pixel(pixel_word_t p);
			shade_t o;
			int px;
			int py;
			int cx;
			logic [7:0] code;
			logic [4:0] bits;
			o = '{p.blue, p.green, p.red, p.alpha};
			px = p.x;
			py = p.y;
			if (px < FRAME_W && py < FRAME_H) begin
				if (px >= BAR_LEFT && px < BAR_LEFT + BAR_WIDTH && py >= BAR_ROW &&
						py < BAR_ROW + BAR_HEIGHT) begin
					o.blue = p.blue >> 1;
					o.green = p.green >> 1;
					o.red = p.red >> 1;
				end
				for (int i = 0; i < TEXT_CHARS; i++) begin
					code = text_bits[8*i +: 8];
					cx = TEXT_LEFT + i * PITCH;
					if (code == 8'h00)
						break;
					if (cx + CHAR_W > FRAME_W || TEXT_ROW + CHAR_H > FRAME_H)
						continue;
					if (px >= cx && px < cx + CHAR_W && py >= TEXT_ROW &&
							py < TEXT_ROW + CHAR_H) begin
						bits = font_row(code, py - TEXT_ROW);
						if (bits[4 - (px - cx)])
							o = {color[23:16], color[15:8], color[7:0], 8'hFF};
						break;
					end
				end
			end
			return o;
		endfunction

		function void note_pixel(pixel_word_t p);
			expected_pixels.push_back(overlay_pixel(p));
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void check_pixel(shade_t got);
			shade_t want;
			if (expected_pixels.size() == 0) begin
				$error("output word with no expected word waiting");
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.blue !== want.blue) begin
				$error("out_blue: expected %0d, got %0d", want.blue, got.blue);
				mismatches++;
			end
			if (got.green !== want.green) begin
				$error("out_green: expected %0d, got %0d", want.green, got.green);
				mismatches++;
			end
			if (got.red !== want.red) begin
				$error("out_red: expected %0d, got %0d", want.red, got.red);
				mismatches++;
			end
			if (got.alpha !== want.alpha) begin
				$error("out_alpha: expected %0d, got %0d", want.alpha, got.alpha);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] pixel_x = '0;
	logic [9:0] pixel_y = '0;
	logic [7:0] in_blue = '0;
	logic [7:0] in_green = '0;
	logic [7:0] in_red = '0;
	logic [7:0] in_alpha = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic [7:0] out_alpha;

	int send_idle_pct = 22;
	int recv_idle_pct = 51;
	int stall_stretch = 0;
	string glyph_set = "0123456789.:| InfersmFPS";
	pixel_overlay_tracker tracker = new();

	hud_text_bar_overlay_unit #(
		.FRAME_WIDTH(FRAME_W),
		.FRAME_HEIGHT(FRAME_H),
		.MAX_CHARS(TEXT_CHARS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.in_blue(in_blue),
		.in_green(in_green),
		.in_red(in_red),
		.in_alpha(in_alpha),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_blue(out_blue),
		.out_green(out_green),
		.out_red(out_red),
		.out_alpha(out_alpha)
	);

	always #5 clk = ~clk;

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (stall_stretch > 0) begin
				out_stall <= 1'b1;
				stall_stretch--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_pixel('{out_blue, out_green, out_red, out_alpha});
	end

	task automatic send_pixel(input pixel_word_t p);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= p.x;
		pixel_y <= p.y;
		in_blue <= p.blue;
		in_green <= p.green;
		in_red <= p.red;
		in_alpha <= p.alpha;
		do @(posedge clk); while (in_stall);
		tracker.note_pixel(p);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] index, input logic [63:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		tracker.set_register(index, data);
	endtask

	task automatic write_text(input logic [TEXT_CHARS*8-1:0] text);
		write_register(REG_CHARS_A, text[63:0]);
		write_register(REG_CHARS_B, text[127:64]);
		write_register(REG_CHARS_C, text[191:128]);
		write_register(REG_CHARS_D, text[255:192]);
	endtask

	function automatic logic [7:0] random_code();
		if ($urandom_range(9) < 9)
			return glyph_set[$urandom_range(23, 0)];
		return 8'($urandom_range(255, 1));
	endfunction

	// Characters after the terminator at index len must have no effect.
	function automatic logic [TEXT_CHARS*8-1:0] random_text(int len);
		logic [TEXT_CHARS*8-1:0] t;
		for (int i = 0; i < TEXT_CHARS; i++) begin
			if (i < len)
				t[8*i +: 8] = random_code();
			else if (i == len)
				t[8*i +: 8] = 8'h00;
			else
				t[8*i +: 8] = 8'($urandom_range(255, 0));
		end
		return t;
	endfunction

	// Most words land on the text rows, some on the whole bar, the rest anywhere.
	function automatic pixel_word_t random_pixel();
		pixel_word_t p;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			p.x = 10'($urandom_range(TEXT_LEFT + TEXT_CHARS * PITCH + 4, BAR_LEFT));
			p.y = 10'($urandom_range(TEXT_ROW + CHAR_H, TEXT_ROW - 1));
		end else if (pick < 80) begin
			p.x = 10'($urandom_range(FRAME_W - 1, BAR_LEFT - 16));
			p.y = 10'($urandom_range(BAR_ROW + BAR_HEIGHT + 6, 0));
		end else begin
			p.x = 10'($urandom_range(1023, 0));
			p.y = 10'($urandom_range(1023, 0));
		end
		p.blue = 8'($urandom_range(255, 0));
		p.green = 8'($urandom_range(255, 0));
		p.red = 8'($urandom_range(255, 0));
		p.alpha = 8'($urandom_range(255, 0));
		return p;
	endfunction

	task automatic run_random(input int count, input int hold_at, input int pause_at);
		for (int n = 0; n < count; n++) begin
			send_pixel(random_pixel());
			if (n == hold_at)
				stall_stretch = 60;
			if (n == pause_at)
				drain_pipeline();
		end
		drain_pipeline();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset state: no text, so only the bar edges and the frame bounds matter.
		send_pixel(pixel_word_t'{10'd0, 10'd0, 8'h00, 8'h00, 8'h00, 8'h00});
		send_pixel(pixel_word_t'{10'd1023, 10'd1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_pixel(pixel_word_t'{10'd396, 10'd6, 8'hFF, 8'hFF, 8'hFF, 8'h12});
		send_pixel(pixel_word_t'{10'd395, 10'd6, 8'hFF, 8'hFF, 8'hFF, 8'h34});
		send_pixel(pixel_word_t'{10'd639, 10'd33, 8'hFF, 8'h01, 8'h80, 8'hFF});
		send_pixel(pixel_word_t'{10'd639, 10'd34, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_pixel(pixel_word_t'{10'd396, 10'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_pixel(pixel_word_t'{10'd640, 10'd20, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_pixel(pixel_word_t'{10'd500, 10'd640, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		drain_pipeline();

		// The text reads 8.:|FPSm with the color left at its reset value.
		write_register(REG_CHARS_A, "mSPF|:.8");
		send_pixel(pixel_word_t'{10'd401, 10'd10, 8'h40, 8'h40, 8'h40, 8'h00});
		send_pixel(pixel_word_t'{10'd400, 10'd10, 8'h40, 8'h40, 8'h40, 8'h00});
		send_pixel(pixel_word_t'{10'd405, 10'd12, 8'hFF, 8'hFF, 8'hFF, 8'h00});
		send_pixel(pixel_word_t'{10'd408, 10'd15, 8'h10, 8'h20, 8'h30, 8'h40});
		send_pixel(pixel_word_t'{10'd420, 10'd16, 8'h10, 8'h20, 8'h30, 8'h40});
		send_pixel(pixel_word_t'{10'd400, 10'd17, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		drain_pipeline();

		// Unsupported codes, a terminator at character 16 and writes to spare indexes.
		write_register(REG_CHARS_B, 64'h7F41_80FF_7F41_80FF);
		write_register(REG_CHARS_C, 64'h4949_4949_4949_4900);
		write_register(REG_CHARS_D, "IIIIIIII");
		write_register(REG_COLOR, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int k = REG_SPARE_LO; k <= REG_SPARE_HI; k++)
			write_register(3'(k), 64'h0);
		send_pixel(pixel_word_t'{10'd401, 10'd10, 8'h00, 8'h00, 8'h00, 8'h00});
		send_pixel(pixel_word_t'{10'd449, 10'd10, 8'h00, 8'h00, 8'h00, 8'h00});
		send_pixel(pixel_word_t'{10'd456, 10'd13, 8'h00, 8'h00, 8'h00, 8'h00});
		send_pixel(pixel_word_t'{10'd497, 10'd10, 8'hFF, 8'hFF, 8'hFF, 8'h00});
		send_pixel(pixel_word_t'{10'd503, 10'd10, 8'hFF, 8'hFF, 8'hFF, 8'h00});
		drain_pipeline();

		write_text(random_text($urandom_range(TEXT_CHARS, 0)));
		write_register(REG_COLOR, {$urandom, $urandom});
		run_random(420, 120, -1);

		send_idle_pct = 51;
		recv_idle_pct = 22;
		write_text(random_text(TEXT_CHARS));
		write_register(REG_COLOR, 64'h0);
		run_random(420, -1, 200);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_text({TEXT_CHARS{8'hFF}});
		write_register(REG_COLOR, {$urandom, $urandom});
		run_random(200, 50, -1);

		write_text(random_text($urandom_range(TEXT_CHARS, 0)));
		write_register(REG_COLOR, {$urandom, $urandom});
		run_random(220, 100, -1);

		repeat (6) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
